// ===== sv/wtt_pkg.sv =====
package wtt_pkg;

   localparam int STEP_W    = 6;
   localparam int DIV_STEPS = 33;

   localparam logic [23:0] KINV_Q24 = 24'd10188014;
   localparam logic [23:0] PI_Q20   = 24'd3294199;
   localparam logic [23:0] CRUISE_RESET = 24'd65536;
   localparam logic [23:0] RECIP_RESET  = 24'd65536;

   localparam logic CSR_CRUISE = 1'b0;
   localparam logic CSR_RECIP  = 1'b1;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_START, OP_CORDIC, OP_LEN0, OP_LEN1, OP_ACC,
      OP_TIME0, OP_TIME1, OP_RATE0, OP_RATE1, OP_RATE2, OP_DIVINIT, OP_DIV,
      OP_EMIT_FIRST, OP_EMIT_LAST, OP_EMIT_SINGLE
   } dp_op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_START, ST_SINGLE, ST_CORDIC, ST_LEN0, ST_LEN1, ST_ACC,
      ST_TIME0, ST_TIME1, ST_RATE0, ST_RATE1, ST_RATE2, ST_DIVINIT, ST_DIV,
      ST_EMIT_FIRST, ST_EMIT_LAST
   } ctl_state_type;

   typedef struct packed {
      dp_op_type          op;
      logic [STEP_W-1:0]  step;
      logic               first_seg;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic fin;
   } dp_status_type;

   // arctan(2^-i) in units of pi/2^31
   function automatic logic [31:0] atan_at(input logic [4:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         5'd30: v = 32'h00000001;
         5'd31: v = 32'h00000000;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

// ===== sv/wtt_datapath.sv =====
module wtt_datapath import wtt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [63:0]   req_tdata,
   input  logic          req_tlast,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [23:0]   csr_wdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [167:0]  rsp_tdata,
   output logic          rsp_tlast,
   output logic [1:0]    rsp_tuser
);

   logic [31:0]        cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic               fin_ff, fin_in;
   logic [31:0]        prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [15:0]        prev_head_ff, prev_head_in;
   logic [39:0]        pl_ff, pl_in;
   logic signed [41:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [31:0]        cz_ff, cz_in;
   logic               nil_ff, nil_in;
   logic [15:0]        head_ff, head_in;
   logic [35:0]        len_ff, len_in;
   logic [63:0]        acc_ff, acc_in;
   logic [31:0]        t_ff, t_in;
   logic               neg_ff, neg_in;
   logic [15:0]        absdh_ff, absdh_in;
   logic [39:0]        m1_ff, m1_in;
   logic [63:0]        num_ff, num_in;
   logic [54:0]        rem_ff, rem_in;
   logic [32:0]        q_ff, q_in;
   logic               ovf_ff, ovf_in;
   logic [23:0]        cs_ff, cs_in, recip_ff, recip_in;
   logic               o_valid_ff, o_valid_in;
   logic [167:0]       o_data_ff, o_data_in;
   logic               o_last_ff, o_last_in;
   logic [1:0]         o_user_ff, o_user_in;

   logic [19:0]        mul_a;
   logic [23:0]        mul_b;
   logic [43:0]        mul_p;
   logic signed [32:0] dx, dy;
   logic signed [41:0] dx_w, dy_w, xs, ys;
   logic [39:0]        xc;
   logic [31:0]        zr;
   logic [64:0]        wsum;
   logic [40:0]        plsum;
   logic [15:0]        dh;
   logic [54:0]        den;
   logic [55:0]        r2;
   logic [31:0]        rate, rate_use;
   logic               out_free;

   assign mul_p = mul_a * mul_b;
   assign out_free = !o_valid_ff || rsp_tready;
   assign den = {len_ff, 19'd0};
   assign xc = cx_ff[41] ? 40'd0 : cx_ff[39:0];

   always_comb begin
      if (neg_ff) begin
         rate = (ovf_ff || q_ff > 33'h080000000) ? 32'h80000000 : 32'd0 - q_ff[31:0];
      end else begin
         rate = (ovf_ff || q_ff > 33'h07FFFFFFF) ? 32'h7FFFFFFF : q_ff[31:0];
      end
      rate_use = (!cmd.first_seg && len_ff != 36'd0 && !fin_ff) ? rate : 32'd0;
   end

   always_comb begin
      cur_x_in = cur_x_ff; cur_y_in = cur_y_ff; fin_in = fin_ff;
      prev_x_in = prev_x_ff; prev_y_in = prev_y_ff; prev_head_in = prev_head_ff;
      pl_in = pl_ff; cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; nil_in = nil_ff;
      head_in = head_ff; len_in = len_ff; acc_in = acc_ff; t_in = t_ff;
      neg_in = neg_ff; absdh_in = absdh_ff; m1_in = m1_ff; num_in = num_ff;
      rem_in = rem_ff; q_in = q_ff; ovf_in = ovf_ff;
      cs_in = cs_ff; recip_in = recip_ff;
      o_valid_in = rsp_tready ? 1'b0 : o_valid_ff;
      o_data_in = o_data_ff; o_last_in = o_last_ff; o_user_in = o_user_ff;
      mul_a = 20'd0; mul_b = 24'd0;
      dx = $signed({req_tdata[31], req_tdata[31:0]}) - $signed({prev_x_ff[31], prev_x_ff});
      dy = $signed({req_tdata[63], req_tdata[63:32]}) - $signed({prev_y_ff[31], prev_y_ff});
      dx_w = $signed({{9{dx[32]}}, dx});
      dy_w = $signed({{9{dy[32]}}, dy});
      xs = cx_ff >>> cmd.step[4:0];
      ys = cy_ff >>> cmd.step[4:0];
      zr = cz_ff + 32'h00008000;
      wsum = 65'd0;
      plsum = {1'b0, pl_ff} + {5'd0, len_ff};
      dh = head_ff - prev_head_ff;
      r2 = {rem_ff, num_ff[cmd.step]};

      if (csr_we) begin
         if (csr_index == CSR_CRUISE) cs_in = csr_wdata;
         else recip_in = csr_wdata;
      end

      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            cur_x_in = req_tdata[31:0];
            cur_y_in = req_tdata[63:32];
            fin_in   = req_tlast;
            nil_in   = (dx == 33'sd0) && (dy == 33'sd0);
            // fold the left half plane over before rotating
            if (dx[32]) begin
               cx_in = (42'sd0 - dx_w) <<< 4;
               cy_in = (42'sd0 - dy_w) <<< 4;
               cz_in = 32'h80000000;
            end else begin
               cx_in = dx_w <<< 4;
               cy_in = dy_w <<< 4;
               cz_in = 32'd0;
            end
         end
         OP_START: begin
            prev_x_in = cur_x_ff;
            prev_y_in = cur_y_ff;
            prev_head_in = 16'd0;
            pl_in = 40'd0;
         end
         OP_CORDIC: begin
            if (cy_ff[41]) begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - atan_at(cmd.step[4:0]);
            end else begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + atan_at(cmd.step[4:0]);
            end
         end
         OP_LEN0: begin
            mul_a = xc[19:0];
            mul_b = KINV_Q24;
            acc_in = {20'd0, mul_p};
            head_in = nil_ff ? 16'd0 : zr[31:16];
         end
         OP_LEN1: begin
            mul_a = xc[39:20];
            mul_b = KINV_Q24;
            wsum = {1'b0, acc_ff} + {1'b0, mul_p, 20'd0} + 65'h8000000;
            len_in = nil_ff ? 36'd0 : wsum[63:28];
         end
         OP_ACC: begin
            pl_in = plsum[40] ? 40'hFFFFFFFFFF : plsum[39:0];
            neg_in = dh[15];
            absdh_in = dh[15] ? 16'd0 - dh : dh;
         end
         OP_TIME0: begin
            mul_a = pl_ff[19:0];
            mul_b = recip_ff;
            acc_in = {20'd0, mul_p};
         end
         OP_TIME1: begin
            mul_a = pl_ff[39:20];
            mul_b = recip_ff;
            wsum = {1'b0, acc_ff} + {1'b0, mul_p, 20'd0} + 65'h8000;
            t_in = (wsum[64:48] != 17'd0) ? 32'hFFFFFFFF : wsum[47:16];
         end
         OP_RATE0: begin
            mul_a = {4'd0, absdh_ff};
            mul_b = cs_ff;
            m1_in = mul_p[39:0];
         end
         OP_RATE1: begin
            mul_a = m1_ff[19:0];
            mul_b = PI_Q20;
            acc_in = {20'd0, mul_p};
         end
         OP_RATE2: begin
            mul_a = m1_ff[39:20];
            mul_b = PI_Q20;
            wsum = {1'b0, acc_ff} + {1'b0, mul_p, 20'd0} + {11'd0, len_ff, 18'd0};
            num_in = wsum[63:0];
         end
         OP_DIVINIT: begin
            // quotient at or above 2^33 saturates whatever follows
            ovf_in = {24'd0, num_ff[63:33]} >= den;
            rem_in = {24'd0, num_ff[63:33]};
            q_in = 33'd0;
         end
         OP_DIV: begin
            // remainder stays below the divisor, so 55 bits hold it
            if (r2 >= {1'b0, den}) begin
               rem_in = r2[54:0] - den;
               q_in = {q_ff[31:0], 1'b1};
            end else begin
               rem_in = r2[54:0];
               q_in = {q_ff[31:0], 1'b0};
            end
         end
         OP_EMIT_FIRST: begin
            o_valid_in = 1'b1;
            o_data_in = {32'd0, cs_ff, 32'd0, head_ff, prev_y_ff, prev_x_ff};
            o_last_in = 1'b0;
            o_user_in = 2'b00;
         end
         OP_EMIT_LAST: begin
            o_valid_in = 1'b1;
            o_data_in = {rate_use, fin_ff ? 24'd0 : cs_ff, t_ff, head_ff, cur_y_ff, cur_x_ff};
            o_last_in = 1'b1;
            o_user_in = {fin_ff, len_ff == 36'd0};
            prev_x_in = cur_x_ff;
            prev_y_in = cur_y_ff;
            prev_head_in = fin_ff ? 16'd0 : head_ff;
            if (fin_ff) pl_in = 40'd0;
         end
         OP_EMIT_SINGLE: begin
            o_valid_in = 1'b1;
            o_data_in = {104'd0, cur_y_ff, cur_x_ff};
            o_last_in = 1'b1;
            o_user_in = 2'b10;
            prev_head_in = 16'd0;
            pl_in = 40'd0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff <= 32'd0;
         prev_y_ff <= 32'd0;
         prev_head_ff <= 16'd0;
         pl_ff <= 40'd0;
         cs_ff <= CRUISE_RESET;
         recip_ff <= RECIP_RESET;
         o_valid_ff <= 1'b0;
      end else begin
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         prev_head_ff <= prev_head_in;
         pl_ff <= pl_in;
         cs_ff <= cs_in;
         recip_ff <= recip_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in; cur_y_ff <= cur_y_in; fin_ff <= fin_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; nil_ff <= nil_in;
      head_ff <= head_in; len_ff <= len_in; acc_ff <= acc_in; t_ff <= t_in;
      neg_ff <= neg_in; absdh_ff <= absdh_in; m1_ff <= m1_in; num_ff <= num_in;
      rem_ff <= rem_in; q_ff <= q_in; ovf_ff <= ovf_in;
      o_data_ff <= o_data_in; o_last_ff <= o_last_in; o_user_ff <= o_user_in;
   end

   assign status.out_free = out_free;
   assign status.fin = fin_ff;
   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata = o_data_ff;
   assign rsp_tlast = o_last_ff;
   assign rsp_tuser = o_user_ff;

endmodule

// ===== sv/wtt_controller.sv =====
module wtt_controller import wtt_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          req_tlast,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [1:0] PHASE_WAIT  = 2'd0;
   localparam logic [1:0] PHASE_FIRST = 2'd1;
   localparam logic [1:0] PHASE_RUN   = 2'd2;

   ctl_state_type     state_ff, state_in;
   logic [1:0]        phase_ff, phase_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              in_path;

   assign in_path = (phase_ff == PHASE_FIRST) || (phase_ff == PHASE_RUN);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PHASE_WAIT;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      step_in  = step_ff;
      req_tready = 1'b0;
      cmd.op = OP_NONE;
      cmd.step = step_ff;
      cmd.first_seg = (phase_ff == PHASE_FIRST);
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = OP_LOAD;
               step_in = '0;
               if (in_path) state_in = ST_CORDIC;
               else if (req_tlast) state_in = ST_SINGLE;
               else state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.op = OP_START;
            phase_in = PHASE_FIRST;
            state_in = ST_IDLE;
         end
         ST_SINGLE: begin
            if (status.out_free) begin
               cmd.op = OP_EMIT_SINGLE;
               phase_in = PHASE_WAIT;
               state_in = ST_IDLE;
            end
         end
         ST_CORDIC: begin
            cmd.op = OP_CORDIC;
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               step_in = '0;
               state_in = ST_LEN0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_LEN0:  begin cmd.op = OP_LEN0;  state_in = ST_LEN1;  end
         ST_LEN1:  begin cmd.op = OP_LEN1;  state_in = ST_ACC;   end
         ST_ACC:   begin cmd.op = OP_ACC;   state_in = ST_TIME0; end
         ST_TIME0: begin cmd.op = OP_TIME0; state_in = ST_TIME1; end
         ST_TIME1: begin cmd.op = OP_TIME1; state_in = ST_RATE0; end
         ST_RATE0: begin cmd.op = OP_RATE0; state_in = ST_RATE1; end
         ST_RATE1: begin cmd.op = OP_RATE1; state_in = ST_RATE2; end
         ST_RATE2: begin cmd.op = OP_RATE2; state_in = ST_DIVINIT; end
         ST_DIVINIT: begin
            cmd.op = OP_DIVINIT;
            step_in = STEP_W'(DIV_STEPS - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = OP_DIV;
            if (step_ff == '0) begin
               state_in = (phase_ff == PHASE_FIRST) ? ST_EMIT_FIRST : ST_EMIT_LAST;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_EMIT_FIRST: begin
            if (status.out_free) begin
               cmd.op = OP_EMIT_FIRST;
               state_in = ST_EMIT_LAST;
            end
         end
         ST_EMIT_LAST: begin
            if (status.out_free) begin
               cmd.op = OP_EMIT_LAST;
               phase_in = status.fin ? PHASE_WAIT : PHASE_RUN;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== sv/waypoint_to_trajectory_timing.sv =====
// Channel   Dir  Handshake              Contents
// req_      in   tvalid/tready/tlast    one waypoint; tlast = final point of path
// rsp_      out  tvalid/tready/tlast    one trajectory point; tlast = last of the waypoint
// csr_      in   we (no wait)           index 0 cruise speed, 1 speed reciprocal
//
// A waypoint after the first runs through the CORDIC rotation, the length, time and
// rate products and the 33-step restoring divider for the turn rate, then emits its results.
// A first waypoint is only loaded and stored; a lone final point is emitted on its own.
// Reset is synchronous, active high; it restores both registers and the path state.
// A stalled rsp_ holds the result register; the block keeps working on the next
// waypoint and waits only when it has a new result to load.
module waypoint_to_trajectory_timing import wtt_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,  // pos_x, pos_y
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [167:0]  rsp_tdata,  // out_x, out_y, heading_angle, time_offset,
                                     // linear_speed, angular_rate
   output logic          rsp_tlast,
   output logic [1:0]    rsp_tuser,  // zero_segment, path_end
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [23:0]   csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequence one waypoint through the shared datapath
   wtt_controller #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tlast(req_tlast),
      .status(status), .cmd(cmd)
   );

   // CORDIC, shared multiplier, divider, path state and result register
   wtt_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

endmodule
